>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the torus kernel grid sum block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define TK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define TK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tkgs_pkg.sv
// Package for the torus kernel grid sum block: fixed-point constants,
// divider request/response structs and the Horner divisor tables. No dependencies.
`default_nettype none

package tkgs_pkg;

  localparam int MAX_GRID_DEF  = 256;
  localparam int SUM_FRAC_DEF  = 16;

  localparam int M_W   = 16;
  localparam int N_W   = 9;
  localparam int SUM_W = 64;

  localparam logic [31:0] ONE_Q30      = 32'd1073741824;
  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [29:0] LN2_Q30      = 30'd744261118;
  localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [31:0] TURN_EIGHTH  = 32'h2000_0000;
  localparam logic [63:0] RecipNum     = 64'hFFFF_FFFF;

  typedef enum logic [1:0] {
    HM_COS,
    HM_SIN,
    HM_EXP
  } hmode_t;

  typedef struct packed {
    logic        start;
    logic [30:0] rem_init;
    logic [31:0] feed;
    logic [29:0] divisor;
    logic [5:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
    logic [30:0] rem;
  } div_rsp_t;

  // Divisor of Horner step k for each series.
  function automatic logic [7:0] horner_div(hmode_t mode, logic [3:0] k);
    logic [7:0] d;
    d = 8'd1;
    unique case (mode)
      HM_EXP: d = {4'b0, k};
      HM_SIN: begin
        unique case (k)
          4'd1:    d = 8'd6;
          4'd2:    d = 8'd20;
          4'd3:    d = 8'd42;
          4'd4:    d = 8'd72;
          4'd5:    d = 8'd110;
          4'd6:    d = 8'd156;
          default: d = 8'd1;
        endcase
      end
      HM_COS: begin
        unique case (k)
          4'd1:    d = 8'd2;
          4'd2:    d = 8'd12;
          4'd3:    d = 8'd30;
          4'd4:    d = 8'd56;
          4'd5:    d = 8'd90;
          4'd6:    d = 8'd132;
          default: d = 8'd1;
        endcase
      end
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // floor((2^32 - 1) / d); quotient estimate lands on q or q - 1.
  function automatic logic [31:0] horner_recip(logic [7:0] d);
    logic [31:0] m;
    m = 32'd0;
    unique case (d)
      8'd1:    m = 32'(RecipNum / 1);
      8'd2:    m = 32'(RecipNum / 2);
      8'd3:    m = 32'(RecipNum / 3);
      8'd4:    m = 32'(RecipNum / 4);
      8'd5:    m = 32'(RecipNum / 5);
      8'd6:    m = 32'(RecipNum / 6);
      8'd7:    m = 32'(RecipNum / 7);
      8'd8:    m = 32'(RecipNum / 8);
      8'd9:    m = 32'(RecipNum / 9);
      8'd10:   m = 32'(RecipNum / 10);
      8'd11:   m = 32'(RecipNum / 11);
      8'd12:   m = 32'(RecipNum / 12);
      8'd20:   m = 32'(RecipNum / 20);
      8'd30:   m = 32'(RecipNum / 30);
      8'd42:   m = 32'(RecipNum / 42);
      8'd56:   m = 32'(RecipNum / 56);
      8'd72:   m = 32'(RecipNum / 72);
      8'd90:   m = 32'(RecipNum / 90);
      8'd110:  m = 32'(RecipNum / 110);
      8'd132:  m = 32'(RecipNum / 132);
      8'd156:  m = 32'(RecipNum / 156);
      default: m = 32'd0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tkgs_div.sv
// Restoring divider, one quotient bit per cycle, shared by the phase and
// exponent-range reductions. Depends on tkgs_pkg.
`default_nettype none

module tkgs_div (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire tkgs_pkg::div_req_t req,
  output tkgs_pkg::div_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [30:0] rem_r;
  logic [31:0] feed_r;
  logic [29:0] div_r;
  logic [31:0] quot_r;

  logic [31:0] trial;
  logic [31:0] diff;
  logic        fits;

  assign trial = {rem_r, feed_r[31]};
  assign fits  = trial >= {2'b0, div_r};
  assign diff  = trial - {2'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == 6'd1);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
        rem_r  <= req.rem_init;
        feed_r <= req.feed;
        div_r  <= req.divisor;
        quot_r <= '0;
      end else if (busy_r) begin
        rem_r  <= fits ? diff[30:0] : trial[30:0];
        quot_r <= {quot_r[30:0], fits};
        feed_r <= {feed_r[30:0], 1'b0};
        cnt_r  <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

>>> hw/rtl/torus_kernel_grid_sum.sv
// Top level of the torus kernel grid sum block: sequencer, shared multiplier,
// square root and accumulator. Depends on tkgs_pkg, tkgs_div, assert_macros.svh.
`default_nettype none

//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in_     | input     | in_valid / in_ready | concentration (Q5.11), rows, cols
//  out_    | output    | out_valid/out_ready | kernel_sum (Q48.16), saturated
//
//  Each grid point runs the 32-step divider for its column phase (the row
//  phase is divided once per row), the 32-step square root and the 18 Horner
//  steps, each an issue, multiply, reciprocal and correct state, through the
//  one 32x32 multiplier; the sine branch adds one more product. An empty grid
//  goes straight to the final state. in_ready is high only while idle.
//  The result sits in an output register; a stalled out_ready holds the next
//  result in the final state. Reset is synchronous, active low.

`include "assert_macros.svh"

module torus_kernel_grid_sum #(
  parameter int MAX_GRID      = tkgs_pkg::MAX_GRID_DEF,
  parameter int SUM_FRAC_BITS = tkgs_pkg::SUM_FRAC_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [tkgs_pkg::M_W-1:0]   in_concentration,
  input  wire logic        [tkgs_pkg::N_W-1:0]   in_rows,
  input  wire logic        [tkgs_pkg::N_W-1:0]   in_cols,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic             [tkgs_pkg::SUM_W-1:0] out_kernel_sum,
  output logic                                   out_saturated
);

  typedef enum logic [4:0] {
    S_IDLE, S_UST, S_UWAIT, S_VST, S_VWAIT, S_SQU, S_SQV, S_SQS, S_SQRT,
    S_CFOLD, S_CX, S_CX2, S_H_ISS, S_H_MUL, S_H_REC, S_H_COR, S_SIN_ISS,
    S_SIN_GET, S_AMUL, S_AGET, S_KST, S_KWAIT, S_TERM, S_ACC, S_DONE
  } state_t;

  localparam int NW = tkgs_pkg::N_W;

  state_t                state_r;
  logic                  mneg_r;
  logic [16:0]           mmag_r;
  logic [NW-1:0]         n1_r, n2_r, row_r, col_r;
  logic [31:0]           u_r, v_r;
  logic [63:0]           sq_r, sval_r, sres_r;
  logic [4:0]            scnt_r;
  logic                  neg_r;
  tkgs_pkg::hmode_t      mode_r;
  logic [29:0]           x_r, h_r;
  logic [31:0]           t_r, y_r, q0_r;
  logic [3:0]            hcnt_r;
  logic                  aneg_r;
  logic [34:0]           amag_r;
  logic [6:0]            k_r;
  logic [63:0]           term_r, acc_r, prod_r;
  logic                  sat_r;
  logic                  out_valid_r, out_sat_r;
  logic [63:0]           out_sum_r;

  tkgs_pkg::div_req_t div_req;
  tkgs_pkg::div_rsp_t div_rsp;

  logic [31:0] mul_a, mul_b;
  logic [NW-1:0] rows_cl, cols_cl;
  logic [16:0] mmag_in;
  logic [63:0] sbit, strial;
  logic [31:0] p1, p2;
  logic [29:0] q_c;
  logic        negf_c, sin_c;
  logic [7:0]  d_c;
  logic [31:0] recip_c, rem_c, qq_c, t_nxt;
  logic [7:0]  sh_c, nsh_c;
  logic [63:0] term_nxt;
  logic [64:0] sum65;
  logic [4:0]  qm;
  logic [29:0] rm;
  logic [6:0]  k_nxt;

  tkgs_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Fold a phase into the first half turn.
  function automatic logic [31:0] fold_phase(logic [31:0] q);
    logic [31:0] r;
    r = q;
    if (q > tkgs_pkg::TURN_HALF) r = 32'(33'h1_0000_0000 - {1'b0, q});
    return r;
  endfunction

  // Clamp sizes; the clamp value only applies when it is below the port range.
  assign rows_cl = ({23'b0, in_rows} > 32'(MAX_GRID)) ? NW'(MAX_GRID) : in_rows;
  assign cols_cl = ({23'b0, in_cols} > 32'(MAX_GRID)) ? NW'(MAX_GRID) : in_cols;
  assign mmag_in = in_concentration[15] ? 17'h10000 - {1'b0, in_concentration}
                                        : {1'b0, in_concentration};

  // Square root step: trial bit at 2 * scnt.
  assign sbit   = 64'd1 << {scnt_r, 1'b0};
  assign strial = sres_r + sbit;

  // Fold the turn count r (cos of 2*pi*r, since the doubling cancels the half).
  always_comb begin
    p1     = (sres_r[31:0] > tkgs_pkg::TURN_HALF)
             ? 32'(33'h1_0000_0000 - {1'b0, sres_r[31:0]}) : sres_r[31:0];
    negf_c = p1 > tkgs_pkg::TURN_QUARTER;
    p2     = negf_c ? tkgs_pkg::TURN_HALF - p1 : p1;
    sin_c  = p2 > tkgs_pkg::TURN_EIGHTH;
    q_c    = sin_c ? 30'(tkgs_pkg::TURN_QUARTER - p2) : p2[29:0];
  end

  // Horner step: divide by a constant through a reciprocal, fix up by one.
  assign d_c     = tkgs_pkg::horner_div(mode_r, hcnt_r);
  assign recip_c = tkgs_pkg::horner_recip(d_c);
  assign rem_c   = y_r - prod_r[31:0];
  assign qq_c    = q0_r + 32'(rem_c >= {24'b0, d_c});
  assign t_nxt   = (mode_r == tkgs_pkg::HM_EXP) ? tkgs_pkg::ONE_Q30 + qq_c
                                                : tkgs_pkg::ONE_Q30 - qq_c;

  // Floor reduction of the exponent argument by ln 2.
  assign qm    = div_rsp.quot[4:0];
  assign rm    = div_rsp.rem[29:0];
  assign k_nxt = !aneg_r ? {2'b0, qm}
               : (rm == 30'd0) ? 7'(-{2'b0, qm}) : 7'(-{2'b0, qm} - 7'd1);

  // Scale exp(f) by 2^k into the sum's fixed point.
  always_comb begin
    sh_c     = {k_r[6], k_r} + 8'(SUM_FRAC_BITS) - 8'd30;
    nsh_c    = ~sh_c + 8'd1;
    term_nxt = '0;
    if (!sh_c[7]) begin
      if (sh_c >= 8'd32) term_nxt = '1;
      else               term_nxt = {32'b0, t_r} << sh_c[4:0];
    end else if (nsh_c < 8'd64) begin
      term_nxt = {32'b0, t_r} >> nsh_c[5:0];
    end
  end

  assign sum65 = {1'b0, acc_r} + {1'b0, term_r};

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQU:     begin mul_a = u_r;                mul_b = u_r;               end
      S_SQV:     begin mul_a = v_r;                mul_b = v_r;               end
      S_CFOLD:   begin mul_a = {2'b0, q_c};        mul_b = tkgs_pkg::PI_Q30;  end
      S_CX:      begin mul_a = {2'b0, prod_r[60:31]}; mul_b = {2'b0, prod_r[60:31]}; end
      S_H_ISS:   begin mul_a = t_r;                mul_b = {2'b0, h_r};       end
      S_H_MUL:   begin mul_a = prod_r[61:30];      mul_b = recip_c;           end
      S_H_REC:   begin mul_a = prod_r[63:32];      mul_b = {24'b0, d_c};      end
      S_SIN_ISS: begin mul_a = {2'b0, x_r};        mul_b = t_r;               end
      S_AMUL:    begin mul_a = {15'b0, mmag_r};    mul_b = t_r;               end
      default:   begin mul_a = '0;                 mul_b = '0;                end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  // Divider requests.
  always_comb begin
    div_req = '0;
    unique case (state_r)
      S_UST: begin
        div_req.start    = 1'b1;
        div_req.rem_init = 31'(row_r);
        div_req.divisor  = 30'(n1_r);
        div_req.steps    = 6'd32;
      end
      S_VST: begin
        div_req.start    = 1'b1;
        div_req.rem_init = 31'(col_r);
        div_req.divisor  = 30'(n2_r);
        div_req.steps    = 6'd32;
      end
      S_KST: begin
        div_req.start    = 1'b1;
        div_req.rem_init = {1'b0, amag_r[34:5]};
        div_req.feed     = {amag_r[4:0], 27'b0};
        div_req.divisor  = tkgs_pkg::LN2_Q30;
        div_req.steps    = 6'd5;
      end
      default: div_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      sat_r       <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      // Drop the result once transferred; the final state loads the next one.
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mneg_r <= in_concentration[15];
            mmag_r <= mmag_in;
            n1_r   <= rows_cl;
            n2_r   <= cols_cl;
            acc_r  <= '0;
            sat_r  <= 1'b0;
            row_r  <= '0;
            col_r  <= '0;
            if (rows_cl == '0 || cols_cl == '0) state_r <= S_DONE;
            else                                state_r <= S_UST;
          end
        end
        S_UST:   state_r <= S_UWAIT;
        S_UWAIT: begin
          if (div_rsp.done) begin
            u_r     <= fold_phase(div_rsp.quot);
            state_r <= S_VST;
          end
        end
        S_VST:   state_r <= S_VWAIT;
        S_VWAIT: begin
          if (div_rsp.done) begin
            v_r     <= fold_phase(div_rsp.quot);
            state_r <= S_SQU;
          end
        end
        S_SQU: state_r <= S_SQV;
        S_SQV: begin
          sq_r    <= prod_r;
          state_r <= S_SQS;
        end
        S_SQS: begin
          sval_r  <= sq_r + prod_r;
          sres_r  <= '0;
          scnt_r  <= 5'd31;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (sval_r >= strial) begin
            sval_r <= sval_r - strial;
            sres_r <= (sres_r >> 1) + sbit;
          end else begin
            sres_r <= sres_r >> 1;
          end
          if (scnt_r == 5'd0) state_r <= S_CFOLD;
          else                scnt_r  <= scnt_r - 5'd1;
        end
        S_CFOLD: begin
          neg_r   <= negf_c;
          mode_r  <= sin_c ? tkgs_pkg::HM_SIN : tkgs_pkg::HM_COS;
          state_r <= S_CX;
        end
        S_CX: begin
          x_r     <= prod_r[60:31];
          state_r <= S_CX2;
        end
        S_CX2: begin
          h_r     <= prod_r[59:30];
          t_r     <= tkgs_pkg::ONE_Q30;
          hcnt_r  <= 4'd6;
          state_r <= S_H_ISS;
        end
        S_H_ISS: state_r <= S_H_MUL;
        S_H_MUL: begin
          y_r     <= prod_r[61:30];
          state_r <= S_H_REC;
        end
        S_H_REC: begin
          q0_r    <= prod_r[63:32];
          state_r <= S_H_COR;
        end
        S_H_COR: begin
          t_r <= t_nxt;
          if (hcnt_r == 4'd1) begin
            priority case (mode_r)
              tkgs_pkg::HM_EXP: state_r <= S_TERM;
              tkgs_pkg::HM_SIN: state_r <= S_SIN_ISS;
              default:          state_r <= S_AMUL;
            endcase
          end else begin
            hcnt_r  <= hcnt_r - 4'd1;
            state_r <= S_H_ISS;
          end
        end
        S_SIN_ISS: state_r <= S_SIN_GET;
        S_SIN_GET: begin
          t_r     <= {2'b0, prod_r[59:30]};
          state_r <= S_AMUL;
        end
        S_AMUL: state_r <= S_AGET;
        S_AGET: begin
          amag_r  <= prod_r[45:11];
          aneg_r  <= mneg_r ^ neg_r;
          state_r <= S_KST;
        end
        S_KST:   state_r <= S_KWAIT;
        S_KWAIT: begin
          if (div_rsp.done) begin
            k_r     <= k_nxt;
            h_r     <= (aneg_r && rm != 30'd0) ? tkgs_pkg::LN2_Q30 - rm : rm;
            t_r     <= tkgs_pkg::ONE_Q30;
            mode_r  <= tkgs_pkg::HM_EXP;
            hcnt_r  <= 4'd12;
            state_r <= S_H_ISS;
          end
        end
        S_TERM: begin
          term_r  <= term_nxt;
          state_r <= S_ACC;
        end
        S_ACC: begin
          // Stick at all ones on overflow.
          if (sum65[64]) begin
            acc_r <= '1;
            sat_r <= 1'b1;
          end else begin
            acc_r <= sum65[63:0];
          end
          if ({1'b0, col_r} + 10'd1 < {1'b0, n2_r}) begin
            col_r   <= col_r + 1'b1;
            state_r <= S_VST;
          end else if ({1'b0, row_r} + 10'd1 < {1'b0, n1_r}) begin
            row_r   <= row_r + 1'b1;
            col_r   <= '0;
            state_r <= S_UST;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (!out_valid_r || out_ready) begin
            out_sum_r   <= acc_r;
            out_sat_r   <= sat_r;
            out_valid_r <= 1'b1;
            acc_r       <= '0;
            row_r       <= '0;
            col_r       <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_kernel_sum = out_sum_r;
  assign out_saturated  = out_sat_r;

  `TK_ASSERT_NXT(a_empty_grid, in_valid && in_ready && (in_rows == '0 || in_cols == '0), state_r == S_DONE, "empty grid did not finish at once")
  `TK_ASSERT_IMP(a_sat_max, out_valid && out_saturated, &out_kernel_sum, "saturated result is not all ones")
  `TK_ASSERT_IMP(a_div_free, div_req.start, !div_rsp.busy, "divider started while busy")
  `TK_ASSERT_IMP(a_idx_range, state_r != S_IDLE && state_r != S_DONE, row_r < n1_r && col_r < n2_r, "grid index out of range")

endmodule

`default_nettype wire
